[rtl/assert_macros.svh]
// Assertion helpers used by the enumerator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/fce_pkg.sv]
// ----------------------------------------------------------------------------
// fce_pkg
// Types and constants of the formal concept enumerator.
// ----------------------------------------------------------------------------
package fce_pkg;
	localparam int MaxObjects  = 64;
	localparam int MaxFeatures = 64;
	localparam int StackSlots  = MaxFeatures + 1;
	localparam int ObjW   = $clog2(MaxObjects);
	localparam int SlotW  = $clog2(StackSlots + 1);
	localparam int SlotAw = $clog2(StackSlots);
	localparam int CountW = 7;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_NEXT    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	localparam logic CFG_OBJECTS  = 1'b0;
	localparam logic CFG_FEATURES = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT_SCAN,
		ST_ROOT_LAST,
		ST_ROOT_EMIT,
		ST_POP_READ,
		ST_POP_WAIT,
		ST_SEARCH,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_CHECK,
		ST_DONE
	} state_t;

	function automatic logic [63:0] low_bits(input logic [CountW-1:0] n);
		logic [63:0] m;
		begin
			m = '0;
			for (int k = 0; k < 64; k++) begin
				if (k < n)
					m[k] = 1'b1;
			end
			return m;
		end
	endfunction
endpackage

[rtl/fce_ram.sv]
// ----------------------------------------------------------------------------
// fce_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fce_ram #(
	parameter int Width = 64,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/formal_concept_enumerator.sv]
// ----------------------------------------------------------------------------
// formal_concept_enumerator
// Close-by-One enumeration of the formal concepts of a binary table.
// ----------------------------------------------------------------------------
// Input words carry a command: load one object row, restart the walk, or
// ask for the next concept. Only a next request gives an output word:
// extent and intent masks, or exhausted with both masks zero.
// Configuration writes (index 0 object count, 1 feature count) are taken
// whenever the block is idle and no input word is taken in that cycle.
// One item is taken at a time. Load and restart are done in the cycle
// they are taken. The root concept comes after a scan of every object
// row, and an exhausted answer by way of the done state. Otherwise every
// candidate feature tried passes frame read, search, one row per cycle
// from the row memory and check, and a frame with no candidate left is
// popped after its read and search.
// After reset the walk starts at the closure of the empty feature set;
// rows hold nothing useful until loaded. A stalled output word holds
// steady, and a new input item is accepted only once it has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module formal_concept_enumerator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [5:0]  row_index,
	input  logic [63:0] row_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] extent_mask,
	output logic [63:0] intent_mask,
	output logic        exhausted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	fce_pkg::state_t state_q, state_d;

	logic [6:0] obj_cnt_q, feat_cnt_q;
	logic [fce_pkg::SlotW-1:0] depth_q;
	logic root_pending_q, finished_q;

	logic [63:0] b_q, cand_q, ext_q, int_q, fmask;
	logic [6:0]  feat_i_q, obj_q;
	logic [6:0]  nobj, nfeat;

	// row memory
	logic                      row_we;
	logic [fce_pkg::ObjW-1:0]  row_raddr;
	logic [63:0]               row_rdata;

	// stack memory: intent and next feature in one word
	logic                         stk_we;
	logic [fce_pkg::SlotAw-1:0]   stk_waddr, stk_raddr;
	logic [70:0]                  stk_wdata, stk_rdata;

	logic accept_in, out_take;
	logic [63:0] cand_b;

	assign nobj  = (obj_cnt_q > 7'(fce_pkg::MaxObjects)) ? 7'(fce_pkg::MaxObjects) : obj_cnt_q;
	assign nfeat = (feat_cnt_q > 7'(fce_pkg::MaxFeatures)) ?
		7'(fce_pkg::MaxFeatures) : feat_cnt_q;
	assign fmask = fce_pkg::low_bits(nfeat);

	assign in_stall  = (state_q != fce_pkg::ST_IDLE) || out_valid;
	assign accept_in = in_valid && !in_stall;
	assign cfg_ready = (state_q == fce_pkg::ST_IDLE) && !accept_in;
	assign out_take  = out_valid && !out_stall;

	fce_ram #(.Width(64), .Depth(fce_pkg::MaxObjects)) u_rows (
		.clk(clk), .we(row_we), .waddr(row_index), .wdata(row_bits),
		.raddr(row_raddr), .rdata(row_rdata)
	);

	fce_ram #(.Width(71), .Depth(fce_pkg::StackSlots)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign row_we    = accept_in && (command == fce_pkg::CMD_LOAD);
	assign row_raddr = obj_q[fce_pkg::ObjW-1:0];

	// Candidate feature search over the popped frame, first free bit at or
	// above feat_i_q.
	logic [6:0] next_i;
	logic       found;
	always_comb begin
		next_i = nfeat;
		found  = 1'b0;
		for (int k = 63; k >= 0; k--) begin
			if (7'(k) >= feat_i_q && 7'(k) < nfeat && !b_q[k]) begin
				next_i = 7'(k);
				found  = 1'b1;
			end
		end
	end

	assign cand_b = (b_q | (64'd1 << next_i[5:0])) & fmask;

	logic canon;
	assign canon = ((int_q & ~b_q & fce_pkg::low_bits(feat_i_q - 7'd1)) == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fce_pkg::ST_IDLE: begin
				if (accept_in && command == fce_pkg::CMD_NEXT) begin
					if (finished_q)
						state_d = fce_pkg::ST_DONE;
					else if (root_pending_q)
						state_d = (nobj == '0) ? fce_pkg::ST_ROOT_LAST :
							fce_pkg::ST_ROOT_SCAN;
					else
						state_d = fce_pkg::ST_POP_READ;
				end
			end
			fce_pkg::ST_ROOT_SCAN:
				if (obj_q + 7'd1 >= nobj) state_d = fce_pkg::ST_ROOT_LAST;
			fce_pkg::ST_ROOT_LAST: state_d = fce_pkg::ST_ROOT_EMIT;
			fce_pkg::ST_ROOT_EMIT: state_d = fce_pkg::ST_IDLE;
			fce_pkg::ST_POP_READ:
				state_d = (depth_q == '0) ? fce_pkg::ST_DONE : fce_pkg::ST_POP_WAIT;
			fce_pkg::ST_POP_WAIT: state_d = fce_pkg::ST_SEARCH;
			fce_pkg::ST_SEARCH: begin
				if (!found)
					state_d = fce_pkg::ST_POP_READ;
				else
					state_d = (nobj == '0) ? fce_pkg::ST_SCAN_LAST : fce_pkg::ST_SCAN;
			end
			fce_pkg::ST_SCAN:
				if (obj_q + 7'd1 >= nobj) state_d = fce_pkg::ST_SCAN_LAST;
			fce_pkg::ST_SCAN_LAST: state_d = fce_pkg::ST_CHECK;
			fce_pkg::ST_CHECK:
				state_d = (canon && depth_q < 7'(fce_pkg::StackSlots)) ?
					fce_pkg::ST_IDLE : fce_pkg::ST_POP_READ;
			fce_pkg::ST_DONE: state_d = fce_pkg::ST_IDLE;
			default: state_d = fce_pkg::ST_IDLE;
		endcase
	end

	// stack memory control
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_raddr = depth_q - 7'd1;
		unique case (state_q)
			fce_pkg::ST_ROOT_EMIT: begin
				stk_we    = 1'b1;
				stk_wdata = {7'd0, int_q & fmask};
			end
			fce_pkg::ST_SEARCH: begin
				// Advance the frame's candidate before the closure.
				stk_we    = found;
				stk_waddr = depth_q - 7'd1;
				stk_wdata = {next_i + 7'd1, b_q};
			end
			fce_pkg::ST_CHECK: begin
				stk_we    = canon && depth_q < 7'(fce_pkg::StackSlots);
				stk_waddr = depth_q;
				stk_wdata = {feat_i_q, int_q & fmask};
			end
			default: ;
		endcase
	end

	// The row read of object obj_q returns in the next cycle; rows pipeline
	// through ext/int accumulation using a delayed object number.
	logic [6:0] obj_s1;
	logic       scan_s1;
	logic       row_hit;
	assign row_hit = ((row_rdata & cand_q) == cand_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= fce_pkg::ST_IDLE;
			obj_cnt_q      <= 7'd64;
			feat_cnt_q     <= 7'd64;
			depth_q        <= '0;
			root_pending_q <= 1'b1;
			finished_q     <= 1'b0;
			out_valid      <= 1'b0;
			scan_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fce_pkg::CFG_OBJECTS)
					obj_cnt_q <= cfg_data;
				else
					feat_cnt_q <= cfg_data;
			end
			if (out_take)
				out_valid <= 1'b0;
			scan_s1 <= (state_q == fce_pkg::ST_ROOT_SCAN) || (state_q == fce_pkg::ST_SCAN);
			if (accept_in && command == fce_pkg::CMD_RESTART) begin
				depth_q        <= '0;
				root_pending_q <= 1'b1;
				finished_q     <= 1'b0;
			end
			unique case (state_q)
				fce_pkg::ST_ROOT_EMIT: begin
					root_pending_q <= 1'b0;
					depth_q        <= 7'd1;
					out_valid      <= 1'b1;
				end
				fce_pkg::ST_POP_READ:
					if (depth_q == '0) finished_q <= 1'b1;
				fce_pkg::ST_SEARCH:
					if (!found) depth_q <= depth_q - 7'd1;
				fce_pkg::ST_CHECK:
					if (canon && depth_q < 7'(fce_pkg::StackSlots)) begin
						depth_q   <= depth_q + 7'd1;
						out_valid <= 1'b1;
					end
				fce_pkg::ST_DONE: out_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		obj_s1 <= obj_q;
		if (scan_s1 && row_hit) begin
			ext_q[obj_s1[5:0]] <= 1'b1;
			int_q <= int_q & row_rdata;
		end
		unique case (state_q)
			fce_pkg::ST_IDLE: begin
				obj_q  <= '0;
				cand_q <= '0;
				ext_q  <= '0;
				int_q  <= fmask;
			end
			fce_pkg::ST_ROOT_SCAN, fce_pkg::ST_SCAN: obj_q <= obj_q + 7'd1;
			fce_pkg::ST_POP_WAIT: begin
				b_q      <= stk_rdata[63:0];
				feat_i_q <= stk_rdata[70:64];
			end
			fce_pkg::ST_SEARCH: begin
				feat_i_q <= next_i + 7'd1;
				cand_q   <= cand_b;
				obj_q    <= '0;
				ext_q    <= '0;
				int_q    <= fmask;
			end
			default: ;
		endcase
		unique case (state_q)
			fce_pkg::ST_ROOT_EMIT, fce_pkg::ST_CHECK: begin
				extent_mask <= ext_q;
				intent_mask <= int_q & fmask;
				exhausted   <= 1'b0;
			end
			fce_pkg::ST_DONE: begin
				extent_mask <= '0;
				intent_mask <= '0;
				exhausted   <= 1'b1;
			end
			default: ;
		endcase
	end

	`ASSERT_IMP(a_busy_stalls, clk, arst_n, state_q != fce_pkg::ST_IDLE, in_stall)
	`ASSERT_IMP(a_depth_range, clk, arst_n, 1'b1, depth_q <= 7'(fce_pkg::StackSlots))
	`ASSERT_NEXT(a_done_out, clk, arst_n, state_q == fce_pkg::ST_DONE, out_valid && exhausted)
	`ASSERT_IMP(a_finished_empty, clk, arst_n, finished_q, depth_q == '0)
endmodule

[dv/fce_checker.sv]
// ----------------------------------------------------------------------------
// fce_checker
// Watches the input, output and configuration channels of the formal concept
// enumerator, keeps its own Close-by-One walk and compares every output word.
// ----------------------------------------------------------------------------
module fce_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [5:0]  row_index,
	input  logic [63:0] row_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] extent_mask,
	input  logic [63:0] intent_mask,
	input  logic        exhausted,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          concepts_seen,
	output int          exhausted_seen
);
	typedef struct packed {
		logic [63:0] ext;
		logic [63:0] itn;
		logic        exh;
	} concept_t;

	logic [63:0] table_rows [fce_pkg::MaxObjects];
	logic [63:0] frame_intent [fce_pkg::StackSlots];
	int          frame_next [fce_pkg::StackSlots];
	int          walk_depth;
	bit          root_pending;
	bit          walk_done;
	logic [6:0]  n_obj;
	logic [6:0]  n_feat;
	concept_t    concept_q [$];

	function automatic logic [63:0] below(int n);
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int objs_used();
		return (n_obj > fce_pkg::MaxObjects) ? fce_pkg::MaxObjects : int'(n_obj);
	endfunction

	function automatic int feats_used();
		return (n_feat > fce_pkg::MaxFeatures) ? fce_pkg::MaxFeatures : int'(n_feat);
	endfunction

	// Extent of feature set b goes to ext; the closed intent is returned.
	function automatic logic [63:0] close_set(input logic [63:0] b, output logic [63:0] ext);
		logic [63:0] fm;
		logic [63:0] itn;
		fm = below(feats_used());
		ext = '0;
		itn = fm;
		b &= fm;
		for (int o = 0; o < objs_used(); o++) begin
			if ((table_rows[o] & b) == b) begin
				ext[o] = 1'b1;
				itn &= table_rows[o];
			end
		end
		return itn & fm;
	endfunction

	function automatic concept_t next_concept();
		concept_t    c;
		logic [63:0] b;
		logic [63:0] itn;
		logic [63:0] ext;
		int          top;
		int          i;
		int          nf;
		bit          got;
		c = '0;
		got = 1'b0;
		if (root_pending && !walk_done) begin
			itn = close_set('0, ext);
			root_pending = 1'b0;
			frame_intent[0] = itn;
			frame_next[0] = 0;
			walk_depth = 1;
			c.ext = ext;
			c.itn = itn;
			return c;
		end
		while (!walk_done && !got) begin
			if (walk_depth == 0 || walk_depth > fce_pkg::StackSlots) begin
				walk_depth = 0;
				walk_done = 1'b1;
			end else begin
				top = walk_depth - 1;
				b = frame_intent[top];
				nf = feats_used();
				i = frame_next[top];
				while (i < nf && b[i])
					i++;
				if (i >= nf) begin
					walk_depth--;
				end else begin
					frame_next[top] = i + 1;
					itn = close_set(b | (64'd1 << i), ext);
					// Canonical only if no new feature below i appears.
					if ((itn & ~b & below(i)) == '0 && walk_depth < fce_pkg::StackSlots) begin
						frame_intent[walk_depth] = itn;
						frame_next[walk_depth] = i + 1;
						walk_depth++;
						c.ext = ext;
						c.itn = itn;
						got = 1'b1;
					end
				end
			end
		end
		if (!got)
			c.exh = 1'b1;
		return c;
	endfunction

	assign pending = concept_q.size();

	always @(posedge clk or negedge arst_n) begin
		concept_t want;
		if (!arst_n) begin
			for (int k = 0; k < fce_pkg::MaxObjects; k++)
				table_rows[k] = '0;
			for (int k = 0; k < fce_pkg::StackSlots; k++) begin
				frame_intent[k] = '0;
				frame_next[k] = 0;
			end
			n_obj = 7'd64;
			n_feat = 7'd64;
			walk_depth = 0;
			root_pending = 1'b1;
			walk_done = 1'b0;
			concept_q.delete();
			fail_count <= 0;
			concepts_seen <= 0;
			exhausted_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fce_pkg::CFG_OBJECTS)
					n_obj = cfg_data;
				else
					n_feat = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (concept_q.size() == 0) begin
					$error("output word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = concept_q.pop_front();
					if (extent_mask !== want.ext || intent_mask !== want.itn ||
						exhausted !== want.exh)
						fail_count <= fail_count + 1;
					if (extent_mask !== want.ext)
						$error("extent_mask expected %h actual %h", want.ext, extent_mask);
					if (intent_mask !== want.itn)
						$error("intent_mask expected %h actual %h", want.itn, intent_mask);
					if (exhausted !== want.exh)
						$error("exhausted expected %b actual %b", want.exh, exhausted);
					if (want.exh)
						exhausted_seen <= exhausted_seen + 1;
					else
						concepts_seen <= concepts_seen + 1;
				end
			end
			if (in_valid && !in_stall) begin
				case (fce_pkg::cmd_t'(command))
					fce_pkg::CMD_LOAD: table_rows[row_index] = row_bits;
					fce_pkg::CMD_RESTART: begin
						walk_depth = 0;
						root_pending = 1'b1;
						walk_done = 1'b0;
					end
					fce_pkg::CMD_NEXT: concept_q = {concept_q, next_concept()};
					default: ;
				endcase
			end
		end
	end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the formal concept enumerator.
// ----------------------------------------------------------------------------
// Loads a full table, runs short directed walks (tiny tables, zero and
// oversized counts, exhaustion, ignored commands) and then random phases
// with new counts, bursty input and a varying output stall pattern.
// ----------------------------------------------------------------------------
module tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [5:0]  row_index;
	logic [63:0] row_bits;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] extent_mask;
	logic [63:0] intent_mask;
	logic        exhausted;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [6:0]  cfg_data;
	int          fail_count;
	int          pending;
	int          concepts_seen;
	int          exhausted_seen;
	int          burst_left;
	bit          long_hold_req;
	bit          long_hold_done;
	int          hold_left;
	int          stall_mode;
	int          mode_left;

	formal_concept_enumerator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .row_index(row_index), .row_bits(row_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.extent_mask(extent_mask), .intent_mask(intent_mask), .exhausted(exhausted),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fce_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .row_index(row_index), .row_bits(row_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.extent_mask(extent_mask), .intent_mask(intent_mask), .exhausted(exhausted),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.concepts_seen(concepts_seen), .exhausted_seen(exhausted_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: a series of randomly chosen stall patterns, plus one long
	// hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold_req && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_left <= 3000;
			long_hold_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// Sender pacing: bursts of random length, random gaps between them.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	task automatic send_word(input fce_pkg::cmd_t c, input logic [5:0] idx,
		input logic [63:0] bits);
		in_valid <= 1'b1;
		command <= c;
		row_index <= idx;
		row_bits <= bits;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pace();
	endtask

	// Quiet the input and wait until every expected word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_row();
		logic [63:0] a;
		logic [63:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return a;
			1: return a | b;
			2: return a & b;
			default: return ~(a & b & {$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [6:0] pick_count(input bit wide);
		case ($urandom_range(0, 9))
			0: return 7'd1;
			1: return 7'd0;
			2: return wide ? 7'd127 : 7'd9;
			3: return wide ? 7'd64 : 7'd10;
			default: return 7'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int nitems;
		int nphase;
		logic [6:0] nf;
		in_valid = 1'b0;
		command = fce_pkg::CMD_NONE;
		row_index = '0;
		row_bits = '0;
		cfg_valid = 1'b0;
		cfg_index = fce_pkg::CFG_OBJECTS;
		cfg_data = '0;
		long_hold_req = 1'b0;
		burst_left = 0;
		nphase = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole table so no walk ever reads an unwritten row.
		for (int r = 0; r < fce_pkg::MaxObjects; r++)
			send_word(fce_pkg::CMD_LOAD, 6'(r), rand_row());
		drain();

		// Tiny table walked to exhaustion, with loads and junk mid-walk.
		write_reg(fce_pkg::CFG_OBJECTS, 7'd4);
		write_reg(fce_pkg::CFG_FEATURES, 7'd4);
		send_word(fce_pkg::CMD_LOAD, 6'd0, 64'h0000_0000_0000_0003);
		send_word(fce_pkg::CMD_LOAD, 6'd1, 64'h0000_0000_0000_0006);
		send_word(fce_pkg::CMD_LOAD, 6'd2, '1);
		send_word(fce_pkg::CMD_LOAD, 6'd3, '0);
		send_word(fce_pkg::CMD_RESTART, 6'd0, '0);
		repeat (4) send_word(fce_pkg::CMD_NEXT, 6'($urandom), {$urandom, $urandom});
		send_word(fce_pkg::CMD_NONE, 6'd63, '1);
		send_word(fce_pkg::CMD_LOAD, 6'd3, 64'h0000_0000_0000_0009);
		repeat (8) send_word(fce_pkg::CMD_NEXT, 6'd63, '1);
		drain();

		// Zero counts, then counts beyond the maximum on a full table.
		write_reg(fce_pkg::CFG_OBJECTS, 7'd0);
		write_reg(fce_pkg::CFG_FEATURES, 7'd0);
		send_word(fce_pkg::CMD_RESTART, 6'd0, '0);
		repeat (3) send_word(fce_pkg::CMD_NEXT, 6'd0, '0);
		drain();
		write_reg(fce_pkg::CFG_OBJECTS, 7'd127);
		write_reg(fce_pkg::CFG_FEATURES, 7'd127);
		send_word(fce_pkg::CMD_RESTART, 6'd0, '0);
		repeat (4) send_word(fce_pkg::CMD_NEXT, 6'd0, '0);
		drain();

		// Random phases: new counts, a restart, then mostly next requests.
		nitems = 0;
		while (nitems < 48) begin
			nphase++;
			write_reg(fce_pkg::CFG_OBJECTS, pick_count(1'b1));
			// Wide feature counts are slow; allow them only in a few phases.
			nf = pick_count(nphase % 5 == 1);
			write_reg(fce_pkg::CFG_FEATURES, nf);
			send_word(fce_pkg::CMD_RESTART, 6'd0, '0);
			if (nphase == 3)
				long_hold_req = 1'b1;
			for (int k = 0; k < ((nf > 10) ? 5 : 20); k++) begin
				case ($urandom_range(0, 19))
					0, 1: send_word(fce_pkg::CMD_LOAD, 6'($urandom), rand_row());
					2: send_word(fce_pkg::CMD_RESTART, 6'($urandom), {$urandom, $urandom});
					3: send_word(fce_pkg::CMD_NONE, 6'($urandom), {$urandom, $urandom});
					default: send_word(fce_pkg::CMD_NEXT, 6'($urandom),
						{$urandom, $urandom});
				endcase
				nitems++;
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Walked %0d random phases: %0d concepts and %0d exhausted answers checked.",
			nphase, concepts_seen, exhausted_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#1000000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
